// File: src/ubh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ubh_pkg: shared types and constants for the uniform bin histogram
// Item structs, register indexes, operation codes and reset values.
// ----------------------------------------------------------------------------
package ubh_pkg;

  localparam int VAL_W      = 32;   // signed Q16.16 sample and bounds
  localparam int CNT_W      = 32;   // bin counter width
  localparam int BIN_IDX_W  = 10;   // bin index on the item channels
  localparam int BIN_CNT_W  = 11;   // bin_count register width
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam int DEF_NUM_BINS = 1024;

  // operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_RANGE_LOW  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RANGE_HIGH = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BIN_COUNT  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_BIN_SCALE  = 2'd3;

  // register reset values
  localparam logic signed [VAL_W-1:0] RANGE_LOW_RST  = 32'sd0;
  localparam logic signed [VAL_W-1:0] RANGE_HIGH_RST = 32'sd65536;
  localparam logic [BIN_CNT_W-1:0]    BIN_COUNT_RST  = 11'd1024;
  localparam logic [CFG_DATA_W-1:0]   BIN_SCALE_RST  = 32'd67108864;

  typedef struct packed {
    logic                    op;
    logic signed [VAL_W-1:0] sample_value;
    logic [BIN_IDX_W-1:0]    bin_select;
  } ubh_in_t;

  typedef struct packed {
    logic [CNT_W-1:0]     bin_total;
    logic [BIN_IDX_W-1:0] bin_index;
    logic                 in_range;
  } ubh_out_t;

endpackage
`default_nettype wire

// File: src/ubh_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ubh_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module ubh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-first: a same-cycle write is not seen here
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: src/uniform_bin_histogram_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uniform_bin_histogram_top: fixed-width histogram engine
// Bins signed Q16.16 samples into NUM_BINS counters; reads return and clear.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel of items. op ADD bins sample_value, op READ
//           returns bin bin_select and clears it.
//   out_* : valid/ready channel, exactly one result per item, in order.
//   cfg_* : write-only register port (range_low, range_high, bin_count,
//           bin_scale), user writes only while idle; block does not enforce.
// Throughput is one item per cycle unless a held result stalls the pipeline.
// An accepted item passes the input register, range check, 32x32 multiply,
// bin clamp with count memory read, then update and result register. The
// single memory write port retires one read-modify-write per cycle when
// not stalled; back-to-back hits on one bin are forwarded from the previous
// write. Reset restores the configuration and valid registers and starts a
// clearing pass over the count memory, one bin per cycle; in_ready stays
// low until it ends. When out_ready is low with a result held, the whole
// pipeline stalls and in_ready drops in the same cycle.
// ----------------------------------------------------------------------------
module uniform_bin_histogram_top
  import ubh_pkg::*;
#(
  parameter int NUM_BINS = DEF_NUM_BINS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire ubh_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output ubh_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ADDR_W = $clog2(NUM_BINS);
  localparam int WIDE_W = (ADDR_W > BIN_IDX_W) ? ADDR_W : BIN_IDX_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_BINS - 1);

  // configuration
  logic signed [VAL_W-1:0] range_low_r, range_high_r;
  logic [BIN_CNT_W-1:0]    bin_count_r;
  logic [CFG_DATA_W-1:0]   bin_scale_r;

  // pipeline
  logic                    s0_vld_r;
  ubh_in_t                 s0_r;
  logic                    s1_vld_r, s1_op_r, s1_hit_r;
  logic [VAL_W-1:0]        s1_diff_r;
  logic [BIN_IDX_W-1:0]    s1_sel_r;
  logic                    s2_vld_r, s2_op_r, s2_hit_r;
  logic [CNT_W-1:0]        s2_bin_r;
  logic [BIN_IDX_W-1:0]    s2_sel_r;
  logic                    s3_vld_r, s3_op_r, s3_ok_r;
  logic [ADDR_W-1:0]       s3_addr_r;
  logic [BIN_IDX_W-1:0]    s3_sel_r;
  logic                    out_vld_r;
  ubh_out_t                out_r;

  // last write, for read-modify-write forwarding
  logic                    fwd_vld_r;
  logic [ADDR_W-1:0]       fwd_addr_r;
  logic [CNT_W-1:0]        fwd_data_r;

  // clearing pass
  logic                    clr_busy_r;
  logic [ADDR_W-1:0]       clr_addr_r;

  logic                    adv;
  logic                    s1_hit_nxt;
  logic [VAL_W-1:0]        s1_diff_nxt;
  logic [2*VAL_W-1:0]      prod_c;
  logic [31:0]             n_use_c, last_bin_c, bin_clamp_c;
  logic [WIDE_W-1:0]       sel_wide_c;
  logic                    rd_ok_c;
  logic [ADDR_W-1:0]       bin_addr_c, sel_addr_c, s3_addr_nxt;
  logic                    s3_ok_nxt;
  logic [CNT_W-1:0]        ram_rdata, cur_cnt_c, new_cnt_c;
  logic                    upd_en_c;
  logic [WIDE_W-1:0]       addr_wide_c;
  ubh_out_t                out_nxt;
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [CNT_W-1:0]        ram_wdata;

  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv && !clr_busy_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= RANGE_LOW_RST;
      range_high_r <= RANGE_HIGH_RST;
      bin_count_r  <= BIN_COUNT_RST;
      bin_scale_r  <= BIN_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_RANGE_LOW:  range_low_r  <= cfg_wdata;
        CFG_RANGE_HIGH: range_high_r <= cfg_wdata;
        CFG_BIN_COUNT:  bin_count_r  <= cfg_wdata[BIN_CNT_W-1:0];
        CFG_BIN_SCALE:  bin_scale_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_comb begin
    s1_hit_nxt  = (s0_r.op == OP_ADD) &&
                  (s0_r.sample_value >= range_low_r) &&
                  (s0_r.sample_value < range_high_r);
    // in range, so the difference fits in 32 unsigned bits
    s1_diff_nxt = s0_r.sample_value - range_low_r;
  end

  // ---------------------------------------------------------------- stage 2
  assign prod_c = {{VAL_W{1'b0}}, s1_diff_r} * {{VAL_W{1'b0}}, bin_scale_r};

  // ---------------------------------------------------------------- stage 3
  always_comb begin
    if (bin_count_r == '0) begin
      n_use_c = 32'd1;
    end else if (32'(bin_count_r) > 32'(NUM_BINS)) begin
      n_use_c = 32'(NUM_BINS);
    end else begin
      n_use_c = 32'(bin_count_r);
    end
    last_bin_c  = n_use_c - 32'd1;
    bin_clamp_c = (s2_bin_r > last_bin_c) ? last_bin_c : s2_bin_r;
    bin_addr_c  = bin_clamp_c[ADDR_W-1:0];
    sel_wide_c  = WIDE_W'(s2_sel_r);
    sel_addr_c  = sel_wide_c[ADDR_W-1:0];
    rd_ok_c     = 32'(s2_sel_r) < 32'(NUM_BINS);
    if (s2_op_r == OP_READ) begin
      s3_addr_nxt = sel_addr_c;
      s3_ok_nxt   = rd_ok_c;
    end else begin
      s3_addr_nxt = bin_addr_c;
      s3_ok_nxt   = s2_hit_r;
    end
  end

  // ---------------------------------------------------------------- update
  always_comb begin
    cur_cnt_c = (fwd_vld_r && fwd_addr_r == s3_addr_r) ? fwd_data_r : ram_rdata;
    if (s3_op_r == OP_READ) begin
      new_cnt_c = '0;
    end else if (cur_cnt_c == '1) begin
      new_cnt_c = cur_cnt_c;                  // saturate
    end else begin
      new_cnt_c = cur_cnt_c + CNT_W'(1);
    end
    upd_en_c    = adv && s3_vld_r && s3_ok_r;
    addr_wide_c = WIDE_W'(s3_addr_r);

    out_nxt = '0;
    if (s3_op_r == OP_READ) begin
      out_nxt.bin_index = s3_sel_r;
      out_nxt.in_range  = s3_ok_r;
      out_nxt.bin_total = s3_ok_r ? cur_cnt_c : '0;
    end else if (s3_ok_r) begin
      out_nxt.bin_index = addr_wide_c[BIN_IDX_W-1:0];
      out_nxt.in_range  = 1'b1;
      out_nxt.bin_total = new_cnt_c;
    end
  end

  always_comb begin
    if (clr_busy_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = upd_en_c;
      ram_waddr = s3_addr_r;
      ram_wdata = new_cnt_c;
    end
  end

  ubh_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_BINS)
  ) u_ubh_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (adv),
    .rd_addr (s3_addr_nxt),
    .rd_data (ram_rdata)
  );

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r   <= 1'b0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      s3_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      fwd_vld_r  <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      if (adv) begin
        s0_vld_r  <= in_valid && in_ready;
        s1_vld_r  <= s0_vld_r;
        s2_vld_r  <= s1_vld_r;
        s3_vld_r  <= s2_vld_r;
        out_vld_r <= s3_vld_r;
        fwd_vld_r <= upd_en_c;
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == LAST_ADDR) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r       <= in_data;
      s1_op_r    <= s0_r.op;
      s1_hit_r   <= s1_hit_nxt;
      s1_diff_r  <= s1_diff_nxt;
      s1_sel_r   <= s0_r.bin_select;
      s2_op_r    <= s1_op_r;
      s2_hit_r   <= s1_hit_r;
      s2_bin_r   <= prod_c[2*VAL_W-1:VAL_W];
      s2_sel_r   <= s1_sel_r;
      s3_op_r    <= s2_op_r;
      s3_ok_r    <= s3_ok_nxt;
      s3_addr_r  <= s3_addr_nxt;
      s3_sel_r   <= s2_sel_r;
      out_r      <= out_nxt;
      fwd_addr_r <= s3_addr_r;
      fwd_data_r <= new_cnt_c;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: src/ubh_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ubh_checker: port-level checks for the uniform bin histogram
// Watches the item channels of the top level over time.
// ----------------------------------------------------------------------------
module ubh_checker
  import ubh_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire ubh_out_t out_data
);

  // reset empties the output and holds off input for the clearing pass
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("output or input ready active right after reset");

  // a stalled result stalls the whole pipeline, input included
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  // an ignored sample or invalid read reports a zero total
  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.in_range |-> out_data.bin_total == '0)
    else $error("nonzero total on out-of-range result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

endmodule

bind uniform_bin_histogram_top ubh_checker u_ubh_checker (.*);
`default_nettype wire

// File: sim/uniform_bin_histogram_top_tb.sv
// ----------------------------------------------------------------------------
// uniform_bin_histogram_top_tb: self-checking bench for the histogram engine
// Streams add and read items through the valid/ready ports under several
// range, bin count and scale settings. A tracker keeps its own copy of the
// bin counts and checks every result in order, field by field.
// ----------------------------------------------------------------------------
module uniform_bin_histogram_top_tb
  import ubh_pkg::*;
();

  localparam int NB = DEF_NUM_BINS;

  // --------------------------------------------------------------------------
  // Bin count tracker: predicts each result from the accepted item
  // --------------------------------------------------------------------------
  class histogram_tracker;
    longint          lo_bound;
    longint          hi_bound;
    int unsigned     bins_reg;
    logic [31:0]     scale_reg;
    logic [31:0]     bin_tally [NB];
    ubh_out_t        expected_totals [$];
    int              errors;
    int              results;
    int              adds_ignored;
    int              reads;

    function new();
      lo_bound  = longint'(RANGE_LOW_RST);
      hi_bound  = longint'(RANGE_HIGH_RST);
      bins_reg  = 32'(BIN_COUNT_RST);
      scale_reg = BIN_SCALE_RST;
      foreach (bin_tally[i]) bin_tally[i] = '0;
    endfunction

    function int unsigned bins_used();
      if (bins_reg == 0) return 1;
      if (bins_reg > NB) return NB;
      return bins_reg;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        CFG_RANGE_LOW:  lo_bound  = longint'($signed(data));
        CFG_RANGE_HIGH: hi_bound  = longint'($signed(data));
        CFG_BIN_COUNT:  bins_reg  = int'(data[BIN_CNT_W-1:0]);
        CFG_BIN_SCALE:  scale_reg = data;
        default: ;
      endcase
    endfunction

    function void note_transfer(ubh_in_t it);
      ubh_out_t    exp;
      longint      v;
      logic [63:0] diff;
      logic [63:0] prod;
      logic [31:0] bin;
      int unsigned used;
      exp = '0;
      if (it.op == OP_READ) begin
        reads++;
        exp.bin_index = it.bin_select;
        if (int'(it.bin_select) < NB) begin
          exp.bin_total = bin_tally[it.bin_select];
          exp.in_range  = 1'b1;
          bin_tally[it.bin_select] = '0;
        end
      end else begin
        v = longint'($signed(it.sample_value));
        if (v < lo_bound || v >= hi_bound) begin
          adds_ignored++;
        end else begin
          // Q16.16 difference times Q16.16 scale, integer part of the Q32.32 product
          diff = 64'(v - lo_bound);
          prod = diff * {32'b0, scale_reg};
          bin  = prod[63:32];
          used = bins_used();
          if (bin > used - 1) bin = used - 1;
          if (bin_tally[bin] != '1) bin_tally[bin] = bin_tally[bin] + 1;
          exp.bin_total = bin_tally[bin];
          exp.bin_index = bin[BIN_IDX_W-1:0];
          exp.in_range  = 1'b1;
        end
      end
      expected_totals.push_back(exp);
    endfunction

    task flag_mismatch(string what);
      errors++;
      $display("ERROR @%0t: %s", $time, what);
    endtask

    task check_transfer(ubh_out_t got);
      ubh_out_t exp;
      results++;
      if (expected_totals.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: total=%h index=%0d flag=%b",
                                got.bin_total, got.bin_index, got.in_range));
      end else begin
        exp = expected_totals.pop_front();
        if (got.bin_total !== exp.bin_total)
          flag_mismatch($sformatf("result %0d bin_total %h, want %h",
                                  results, got.bin_total, exp.bin_total));
        if (got.bin_index !== exp.bin_index)
          flag_mismatch($sformatf("result %0d bin_index %0d, want %0d",
                                  results, got.bin_index, exp.bin_index));
        if (got.in_range !== exp.in_range)
          flag_mismatch($sformatf("result %0d in_range %b, want %b",
                                  results, got.in_range, exp.in_range));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  ubh_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  ubh_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  histogram_tracker tracker;
  int               send_idle_pct = 18;
  int               recv_idle_pct = 46;
  int               items_sent = 0;
  int               reg_writes = 0;
  logic [31:0]      last_hit = '0;

  always #5 clk = ~clk;

  uniform_bin_histogram_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // result side: random back-pressure, checked at the rising edge
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_transfer(out_data);
  end

  // --------------------------------------------------------------------------
  // Drive tasks
  // --------------------------------------------------------------------------
  task send_item(input ubh_in_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_transfer(it);
    items_sent++;
  endtask

  // sender drops in_valid and holds off until every pending result is out
  task wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.expected_totals.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = data;
    tracker.write_reg(addr, data);
    reg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic ubh_in_t mk(logic op, logic [31:0] v, logic [BIN_IDX_W-1:0] sel);
    ubh_in_t it;
    it.op           = op;
    it.sample_value = v;
    it.bin_select   = sel;
    return it;
  endfunction

  // bins per unit value in Q16.16 for n bins over [lo, hi)
  function automatic logic [31:0] fit_scale(logic [31:0] lo, logic [31:0] hi, int unsigned n);
    longint      width;
    logic [63:0] q;
    width = longint'($signed(hi)) - longint'($signed(lo));
    if (width <= 0) return '0;
    q = (64'(n) << 32) / 64'(width);
    if (q > 64'hFFFF_FFFF) return '1;
    return q[31:0];
  endfunction

  function automatic ubh_in_t rand_item();
    ubh_in_t     it;
    int unsigned pick;
    int unsigned used;
    longint      width;
    logic [63:0] r;
    it.op           = OP_ADD;
    it.sample_value = $urandom;
    it.bin_select   = BIN_IDX_W'($urandom);
    pick  = $urandom_range(99);
    used  = tracker.bins_used();
    width = tracker.hi_bound - tracker.lo_bound;
    if (pick < 22) begin
      it.op = OP_READ;
      if ($urandom_range(3) != 0) it.bin_select = BIN_IDX_W'($urandom_range(used - 1));
    end else if (pick < 32) begin
      // fully random sample, mostly outside a narrow range
    end else if (pick < 40) begin
      case ($urandom_range(3))
        0: it.sample_value = 32'(tracker.lo_bound);
        1: it.sample_value = 32'(tracker.hi_bound - 1);
        2: it.sample_value = 32'(tracker.hi_bound);
        default: it.sample_value = 32'(tracker.lo_bound - 1);
      endcase
    end else if (pick < 54) begin
      // same sample again: back-to-back hits on one bin
      it.sample_value = last_hit;
    end else if (width > 0) begin
      r = {$urandom, $urandom};
      it.sample_value = 32'(tracker.lo_bound + longint'(r % 64'(width)));
      last_hit = it.sample_value;
    end
    return it;
  endfunction

  task run_phase(input logic [31:0] lo, input logic [31:0] hi, input logic [31:0] cnt_word,
                 input logic [31:0] scale, input int count, input bit pause_mid);
    wait_drain();
    write_reg(CFG_RANGE_LOW, lo);
    write_reg(CFG_RANGE_HIGH, hi);
    write_reg(CFG_BIN_COUNT, cnt_word);
    write_reg(CFG_BIN_SCALE, scale);
    last_hit = lo;
    for (int i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2) wait_drain();
      send_item(rand_item());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] tmp;
    int unsigned n;
    tracker = new();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // reset values: [0, 1.0), 1024 bins, 64 counts per bin width of 1/1024
    send_item(mk(OP_ADD, 32'd0, 10'd0));
    send_item(mk(OP_ADD, 32'd0, 10'h3FF));
    send_item(mk(OP_ADD, 32'd65535, 10'd0));
    send_item(mk(OP_ADD, 32'd65536, 10'd0));
    send_item(mk(OP_ADD, 32'hFFFF_FFFF, 10'd0));
    send_item(mk(OP_ADD, 32'h7FFF_FFFF, 10'd0));
    send_item(mk(OP_ADD, 32'h8000_0000, 10'd0));
    send_item(mk(OP_ADD, 32'd64, 10'd0));
    send_item(mk(OP_ADD, 32'd63, 10'd0));
    send_item(mk(OP_READ, 32'd0, 10'd0));
    send_item(mk(OP_READ, 32'd0, 10'd0));
    send_item(mk(OP_READ, 32'h7FFF_FFFF, 10'h3FF));
    send_item(mk(OP_READ, 32'hFFFF_FFFF, 10'd1));

    // inverted range, then empty range: nothing counts
    wait_drain();
    write_reg(CFG_RANGE_LOW, 32'd65536);
    write_reg(CFG_RANGE_HIGH, 32'd0);
    send_item(mk(OP_ADD, 32'd0, 10'd0));
    send_item(mk(OP_ADD, 32'd32768, 10'd0));
    wait_drain();
    write_reg(CFG_RANGE_LOW, 32'd4096);
    write_reg(CFG_RANGE_HIGH, 32'd4096);
    send_item(mk(OP_ADD, 32'd4096, 10'd0));

    // zero bin count acts as a single bin
    wait_drain();
    write_reg(CFG_RANGE_LOW, 32'd0);
    write_reg(CFG_RANGE_HIGH, 32'd65536);
    write_reg(CFG_BIN_COUNT, 32'd0);
    send_item(mk(OP_ADD, 32'd65535, 10'd0));
    send_item(mk(OP_ADD, 32'd0, 10'd0));
    send_item(mk(OP_READ, 32'd0, 10'd0));

    // oversized scale: bins run past the end and clamp to the last one
    wait_drain();
    write_reg(CFG_BIN_COUNT, 32'd4);
    write_reg(CFG_BIN_SCALE, 32'hFFFF_FFFF);
    send_item(mk(OP_ADD, 32'd1, 10'd0));
    send_item(mk(OP_ADD, 32'd2, 10'd0));
    send_item(mk(OP_ADD, 32'd65535, 10'd0));
    send_item(mk(OP_READ, 32'd0, 10'd3));

    // random traffic: sender light gaps, receiver heavy stalls
    run_phase(-32'sd131072, 32'sd229376, 32'd16,
              fit_scale(-32'sd131072, 32'sd229376, 16), 205, 1'b0);
    run_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'd1024,
              fit_scale(32'h8000_0000, 32'h7FFF_FFFF, 1024), 205, 1'b1);

    // roles swapped
    send_idle_pct = 46;
    recv_idle_pct = 18;
    lo = $urandom;
    hi = $urandom;
    if ($signed(lo) > $signed(hi)) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    n = $urandom_range(1, 1024);
    // scale nudged upward so rounding can land past the last bin
    run_phase(lo, hi, 32'(n), fit_scale(lo, hi, n) + $urandom_range(3), 205, 1'b0);
    run_phase(-32'sd5, 32'sd100000, 32'd3, 32'hFFFF_FFFF, 205, 1'b0);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    lo = -$urandom_range(65536 * 8);
    hi = $urandom_range(65536 * 8);
    run_phase(lo, hi, $urandom & ~32'h7FF, $urandom, 205, 1'b1);
    tmp = $urandom;
    run_phase(-32'sd65536, 32'sd65536, {tmp[31:11], 11'h7FF},
              fit_scale(-32'sd65536, 32'sd65536, 1024), 205, 1'b0);

    wait_drain();
    repeat (20) @(negedge clk);
    $display("Run covered %0d items (%0d reads, %0d ignored samples), %0d register writes",
             items_sent, tracker.reads, tracker.adds_ignored, reg_writes);
    $display("%0d results compared, %0d field errors", tracker.results, tracker.errors);
    if (tracker.errors == 0 && tracker.expected_totals.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Timed out with %0d results pending", tracker.expected_totals.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
src/ubh_pkg.sv
src/ubh_ram.sv
src/uniform_bin_histogram_top.sv
src/ubh_checker.sv
sim/uniform_bin_histogram_top_tb.sv
